// ===== sv/bsh_pkg.sv =====
`default_nettype none
package bsh_pkg;

  localparam int COORD_W  = 10;
  localparam int SQ_W     = 19;
  localparam int INV_W    = 25;
  localparam int GAIN_W   = 24;
  localparam int R_W      = 44;
  localparam int ROOT_W   = 30;
  localparam int REM_W    = 31;
  localparam int DD_W     = 2 * ROOT_W;
  localparam int FRAC_Q20 = 20;
  localparam int Q_W      = DD_W - FRAC_Q20;
  localparam int Q_SPLIT  = 20;
  localparam int MP_W     = (Q_W - Q_SPLIT) + GAIN_W;
  localparam int P_W      = 64;
  localparam int P_SHIFT  = 28;
  localparam int H_W      = P_W - P_SHIFT;
  localparam int HEIGHT_W = 16;

  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_ADDR_W-1:0] REG_INV_A_SQ = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_B_SQ = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_GAIN = 8'd2;

  localparam logic [INV_W-1:0]    ONE_Q24    = 25'h1000000;
  localparam logic [ROOT_W-1:0]   ONE_Q20    = 30'h0100000;
  localparam logic [GAIN_W-1:0]   GAIN_RESET = 24'h010000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFF00;

  function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] neg;
    neg = ~v + 1'b1;
    return v[COORD_W-1] ? neg : v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bsh_sqrt.sv =====
`default_nettype none
module bsh_sqrt import bsh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [R_W-1:0]    in_rad,
  input  wire logic              in_floor,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ROOT_W-1:0]      out_root,
  output logic                   out_floor
);

  localparam int STEPS = ROOT_W;
  localparam int N_W   = 2 * ROOT_W;
  localparam int SHIFT = N_W - R_W;

  logic              v    [STEPS];
  logic [R_W-1:0]    rad  [STEPS];
  logic [REM_W-1:0]  rem  [STEPS];
  logic [ROOT_W-1:0] root [STEPS];
  logic              flr  [STEPS];
  logic              adv  [STEPS];

  // one result bit per stage, msb first; radicand is r scaled by 2^16
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic              prev_v;
    logic [R_W-1:0]    prev_rad;
    logic [REM_W-1:0]  prev_rem;
    logic [ROOT_W-1:0] prev_root;
    logic              prev_flr;
    logic              next_adv;
    logic [N_W-1:0]    n;
    logic [1:0]        pair;
    logic [REM_W+1:0]  trial_rem;
    logic [REM_W+1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    if (i == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rad  = in_rad;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_flr  = in_floor;
    end else begin : g_rest
      assign prev_v    = v[i-1];
      assign prev_rad  = rad[i-1];
      assign prev_rem  = rem[i-1];
      assign prev_root = root[i-1];
      assign prev_flr  = flr[i-1];
    end

    if (i == STEPS - 1) begin : g_last
      assign next_adv = out_ready;
    end else begin : g_mid
      assign next_adv = adv[i+1];
    end

    assign adv[i]    = !v[i] || next_adv;
    assign n         = {prev_rad, {SHIFT{1'b0}}};
    assign pair      = n[2*(STEPS-1-i)+1 -: 2];
    assign trial_rem = {prev_rem, pair};
    assign trial     = {1'b0, prev_root, 2'b01};
    assign fits      = trial_rem >= trial;
    // remainder never exceeds twice the partial root, so it fits REM_W
    assign rem_next  = fits ? REM_W'(trial_rem - trial) : REM_W'(trial_rem);
    assign root_next = {prev_root[ROOT_W-2:0], fits};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv[i]) begin
        v[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i] && prev_v) begin
        rad[i]  <= prev_rad;
        rem[i]  <= rem_next;
        root[i] <= root_next;
        flr[i]  <= prev_flr;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[STEPS-1];
  assign out_root  = root[STEPS-1];
  assign out_floor = flr[STEPS-1];

endmodule
`default_nettype wire

// ===== sv/bowl_surface_height.sv =====
`default_nettype none
// channel  | direction | handshake              | payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata: grid_x, grid_y
// m_axis   | out       | m_axis_tvalid/tready   | tdata: height; tuser: on_floor
// cfg      | in        | cfg_valid/cfg_ready    | cfg_addr, cfg_data
//
// one item per clock sustained while m_axis_tready stays high
// most of the pipeline is the square root: 30 stages, one root bit per stage
// reset (synchronous, rst high) empties the pipeline and loads register defaults
// each stage holds its item under stall and bubbles close up, so input is taken
// while the output register waits, until the pipeline is full
module bowl_surface_height import bsh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // grid_x [9:0], grid_y [19:10]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [HEIGHT_W-1:0]        m_axis_tdata,  // height [15:0]
  output logic [0:0]                 m_axis_tuser,  // on_floor [0]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [INV_W-1:0]  inv_a_sq;
  logic [INV_W-1:0]  inv_b_sq;
  logic [GAIN_W-1:0] rise_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_a_sq  <= ONE_Q24;
      inv_b_sq  <= ONE_Q24;
      rise_gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_INV_A_SQ:  inv_a_sq  <= cfg_data;
        REG_INV_B_SQ:  inv_b_sq  <= cfg_data;
        REG_RISE_GAIN: rise_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flags and payload
  logic                f1_v, f2_v, f3_v, e1_v, e2_v, e3_v, e4_v, o_v;
  logic                f1_adv, f2_adv, f3_adv, e1_adv, e2_adv, e3_adv, e4_adv, o_adv;
  logic [SQ_W-1:0]     f1_ax2, f1_ay2;
  logic [R_W-1:0]      f2_ta, f2_tb;
  logic [R_W-1:0]      f3_r;
  logic                f3_floor;
  logic                sq_in_ready, sq_v, sq_floor;
  logic [ROOT_W-1:0]   sq_root;
  logic [ROOT_W-1:0]   e1_d;
  logic                e1_floor;
  logic [Q_W-1:0]      e2_q;
  logic                e2_floor;
  logic [MP_W-1:0]     e3_ph, e3_pl;
  logic                e3_floor;
  logic [H_W-1:0]      e4_h;
  logic                e4_floor;
  logic [HEIGHT_W-1:0] o_height;
  logic                o_floor;

  assign o_adv  = !o_v  || m_axis_tready;
  assign e4_adv = !e4_v || o_adv;
  assign e3_adv = !e3_v || e4_adv;
  assign e2_adv = !e2_v || e3_adv;
  assign e1_adv = !e1_v || e2_adv;
  assign f3_adv = !f3_v || sq_in_ready;
  assign f2_adv = !f2_v || f3_adv;
  assign f1_adv = !f1_v || f2_adv;
  assign s_axis_tready = f1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (f1_adv) f1_v <= s_axis_tvalid;
      if (f2_adv) f2_v <= f1_v;
      if (f3_adv) f3_v <= f2_v;
      if (e1_adv) e1_v <= sq_v;
      if (e2_adv) e2_v <= e1_v;
      if (e3_adv) e3_v <= e2_v;
      if (e4_adv) e4_v <= e3_v;
      if (o_adv)  o_v  <= e4_v;
    end
  end

  // front end: squares, axis products, sum and floor test
  logic [COORD_W-1:0]   mag_x, mag_y;
  logic [2*COORD_W-1:0] sq_x, sq_y;
  logic [R_W-1:0]       r_next;

  always_comb begin
    mag_x  = coord_mag(s_axis_tdata[COORD_W-1:0]);
    mag_y  = coord_mag(s_axis_tdata[2*COORD_W-1:COORD_W]);
    sq_x   = {{COORD_W{1'b0}}, mag_x} * {{COORD_W{1'b0}}, mag_x};
    sq_y   = {{COORD_W{1'b0}}, mag_y} * {{COORD_W{1'b0}}, mag_y};
    r_next = f2_ta + f2_tb;
  end

  always_ff @(posedge clk) begin
    if (f1_adv && s_axis_tvalid) begin
      f1_ax2 <= sq_x[SQ_W-1:0];
      f1_ay2 <= sq_y[SQ_W-1:0];
    end
    if (f2_adv && f1_v) begin
      f2_ta <= R_W'(f1_ax2) * R_W'(inv_a_sq);
      f2_tb <= R_W'(f1_ay2) * R_W'(inv_b_sq);
    end
    if (f3_adv && f2_v) begin
      f3_r     <= r_next;
      f3_floor <= r_next <= R_W'(ONE_Q24);
    end
  end

  bsh_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f3_v),
    .in_ready  (sq_in_ready),
    .in_rad    (f3_r),
    .in_floor  (f3_floor),
    .out_valid (sq_v),
    .out_ready (e1_adv),
    .out_root  (sq_root),
    .out_floor (sq_floor)
  );

  // back end: (sqrt(r) - 1)^2, gain product in two halves, floor zeroing and saturation
  logic [DD_W-1:0] dd;
  logic [P_W-1:0]  p_sum;
  logic [HEIGHT_W-1:0] height_next;

  always_comb begin
    dd    = DD_W'(e1_d) * DD_W'(e1_d);
    p_sum = {e3_ph, {Q_SPLIT{1'b0}}} + P_W'(e3_pl);
    if (e4_floor) begin
      height_next = '0;
    end else if (e4_h > H_W'(HEIGHT_MAX)) begin
      height_next = HEIGHT_MAX;
    end else begin
      height_next = e4_h[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (e1_adv && sq_v) begin
      e1_d     <= (sq_root > ONE_Q20) ? sq_root - ONE_Q20 : '0;
      e1_floor <= sq_floor;
    end
    if (e2_adv && e1_v) begin
      e2_q     <= dd[DD_W-1:FRAC_Q20];
      e2_floor <= e1_floor;
    end
    if (e3_adv && e2_v) begin
      e3_ph    <= MP_W'(e2_q[Q_W-1:Q_SPLIT]) * MP_W'(rise_gain);
      e3_pl    <= MP_W'(e2_q[Q_SPLIT-1:0]) * MP_W'(rise_gain);
      e3_floor <= e2_floor;
    end
    if (e4_adv && e3_v) begin
      e4_h     <= p_sum[P_W-1:P_SHIFT];
      e4_floor <= e3_floor;
    end
    if (o_adv && e4_v) begin
      o_height <= height_next;
      o_floor  <= e4_floor;
    end
  end

  assign m_axis_tvalid   = o_v;
  assign m_axis_tdata    = o_height;
  assign m_axis_tuser[0] = o_floor;

endmodule
`default_nettype wire

// ===== sv/bsh_checker.sv =====
`default_nettype none
module bsh_checker import bsh_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [23:0]           s_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [HEIGHT_W-1:0]   m_axis_tdata,
  input wire logic [0:0]            m_axis_tuser,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // a stalled result keeps its value and flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // floor points are flat
  a_floor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("floor item with non-zero height");

  // saturation bound
  a_height_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= HEIGHT_MAX))
    else $error("height above saturation limit");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind bowl_surface_height bsh_checker u_bsh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_addr      (cfg_addr),
  .cfg_data      (cfg_data)
);
`default_nettype wire

// ===== test/bsh_surface_checker.sv =====
`timescale 1ns / 1ps
// watches the three channels, models the surface height for each accepted
// point and compares results in order
module bsh_surface_checker import bsh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [HEIGHT_W-1:0]   m_axis_tdata,
  input  logic [0:0]            m_axis_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                on_floor;
  } surface_t;

  surface_t heights_due[$];
  logic [INV_W-1:0]  inv_a_sq;
  logic [INV_W-1:0]  inv_b_sq;
  logic [GAIN_W-1:0] wall_gain;
  int miss_count = 0;
  int due_count = 0;

  assign mismatches  = miss_count;
  assign outstanding = due_count;

  // bit-by-bit integer square root, operand stays below 2^60
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = acc | (64'd1 << i);
      if (trial * trial <= n) acc = trial;
    end
    return acc;
  endfunction

  function automatic surface_t surface_at(input logic [COORD_W-1:0] gx,
                                          input logic [COORD_W-1:0] gy);
    int          ax;
    int          ay;
    logic [63:0] sq_x;
    logic [63:0] sq_y;
    logic [63:0] r;
    logic [63:0] root;
    logic [63:0] rise;
    logic [63:0] rise_sq;
    logic [63:0] prod;
    logic [63:0] h;
    surface_t    res;
    ax = $signed(gx);
    ay = $signed(gy);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    sq_x = 64'(ax) * 64'(ax);
    sq_y = 64'(ay) * 64'(ay);
    r = sq_x * 64'(inv_a_sq) + sq_y * 64'(inv_b_sq);
    if (r <= (64'd1 << 24)) begin
      res.height   = '0;
      res.on_floor = 1'b1;
    end else begin
      root    = root_floor(r << 16);
      rise    = root - (64'd1 << 20);
      rise_sq = (rise * rise) >> 20;
      prod    = rise_sq * 64'(wall_gain);
      h       = prod >> 28;
      if (h > 64'(HEIGHT_MAX)) h = 64'(HEIGHT_MAX);
      res.height   = h[HEIGHT_W-1:0];
      res.on_floor = 1'b0;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (miss_count < 10)
      $display("mismatch %0t: %s expected %h got %h", $realtime, what, want, got);
    miss_count++;
  endtask

  always @(posedge clk) begin
    surface_t want;
    if (rst) begin
      inv_a_sq  <= ONE_Q24;
      inv_b_sq  <= ONE_Q24;
      wall_gain <= GAIN_RESET;
      heights_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_INV_A_SQ:  inv_a_sq  <= cfg_data[INV_W-1:0];
          REG_INV_B_SQ:  inv_b_sq  <= cfg_data[INV_W-1:0];
          REG_RISE_GAIN: wall_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        heights_due.push_back(surface_at(s_axis_tdata[9:0], s_axis_tdata[19:10]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (heights_due.size() == 0) begin
          note_mismatch("unexpected item", '0, 32'({m_axis_tuser, m_axis_tdata}));
        end else begin
          want = heights_due.pop_front();
          if (m_axis_tdata !== want.height)
            note_mismatch("height", 32'(want.height), 32'(m_axis_tdata));
          if (m_axis_tuser[0] !== want.on_floor)
            note_mismatch("on_floor", 32'(want.on_floor), 32'(m_axis_tuser));
        end
      end
    end
    due_count <= heights_due.size();
  end

endmodule

// ===== test/tb_bowl_surface_height.sv =====
`timescale 1ns / 1ps
module tb_bowl_surface_height;
  import bsh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [HEIGHT_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int src_idle = 0;
  int sink_stall = 0;
  int cycles = 0;
  int span_x = 511;
  int span_y = 511;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bowl_surface_height dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  bsh_surface_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_point(input int x, input int y);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, y[9:0], x[9:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // let every point in flight come back before touching registers
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0: begin src_idle = 0;  sink_stall = 0;  end
      1: begin src_idle = 47; sink_stall = 0;  end
      2: begin src_idle = 0;  sink_stall = 47; end
      default: begin src_idle = 27; sink_stall = 27; end
    endcase
  endtask

  // reciprocal of a squared semi-axis; also returns a sensible sweep span
  task automatic pick_recip(output logic [CFG_DATA_W-1:0] recip, output int span);
    int semi;
    case ($urandom_range(9))
      0: begin recip = '0; span = 511; end
      1: begin recip = ONE_Q24; span = 4; end
      2: begin recip = 25'($urandom_range(0, 32'h1000000)); span = 511; end
      default: begin
        semi  = $urandom_range(1, 420);
        recip = 25'((32'd1 << 24) / (semi * semi));
        span  = (semi + 40 > 511) ? 511 : semi + 40;
      end
    endcase
  endtask

  task automatic configure_random;
    logic [CFG_DATA_W-1:0] recip;
    logic [CFG_DATA_W-1:0] gain;
    pick_recip(recip, span_x);
    cfg_write(REG_INV_A_SQ, recip);
    pick_recip(recip, span_y);
    cfg_write(REG_INV_B_SQ, recip);
    case ($urandom_range(5))
      0: gain = '0;
      1: gain = 25'h0FFFFFF;
      2: gain = 25'($urandom_range(0, 32'h1FFFFFF));
      default: gain = 25'($urandom_range(0, 32'h40000));
    endcase
    cfg_write(REG_RISE_GAIN, gain);
  endtask

  task automatic send_random_point;
    int x;
    int y;
    if ($urandom_range(3) == 0) begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(0, 1023);
    end else begin
      x = int'($urandom_range(0, 2 * span_x)) - span_x;
      y = int'($urandom_range(0, 2 * span_y)) - span_y;
    end
    send_point(x, y);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // unit circle, unit gain
    send_point(0, 0);
    send_point(1, 0);
    send_point(0, -1);
    send_point(1, 1);
    send_point(2, 0);
    send_point(-1, -1);
    send_point(-512, -512);
    send_point(511, 511);
    send_point(-512, 511);
    send_point(511, -512);
    drain();

    // flat wall
    cfg_write(REG_RISE_GAIN, '0);
    send_point(3, 4);
    send_point(-512, 0);
    drain();

    // a = 2, b unbounded, steepest wall; bit 24 of the gain write is dropped
    cfg_write(REG_RISE_GAIN, 25'h1FFFFFF);
    cfg_write(REG_INV_A_SQ, 25'h0400000);
    cfg_write(REG_INV_B_SQ, '0);
    send_point(2, 0);
    send_point(-2, 500);
    send_point(3, 0);
    drain();

    // writes to unused indexes must not land anywhere
    cfg_write(8'd3, 25'h1FFFFFF);
    cfg_write(8'hFF, 25'h0000000);
    cfg_write(REG_INV_A_SQ, '0);
    cfg_write(REG_INV_B_SQ, ONE_Q24);
    cfg_write(REG_RISE_GAIN, 25'h0000100);
    send_point(300, 0);
    send_point(0, 2);
    send_point(0, -512);
    send_point(-512, 1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_pace(ph % 4);
      configure_random();
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_point();
      drain();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bsh_pkg.sv
sv/bsh_sqrt.sv
sv/bowl_surface_height.sv
sv/bsh_checker.sv
test/bsh_surface_checker.sv
test/tb_bowl_surface_height.sv
